// ----- hdl/lrrt_pkg.sv -----
// lrrt_pkg: shared constants for the longest-repeat-run segment tree.
// No dependencies; used by longest_repeat_run_tree.
package lrrt_pkg;

  localparam int DEF_POSITIONS = 1024;

  localparam int POS_W  = 10;
  localparam int CHAR_W = 8;
  localparam int OUT_W  = 11;

  // stored character: byte plus a padding flag in the top bit
  localparam int SCHAR_W = CHAR_W + 1;
  localparam logic [SCHAR_W-1:0] PAD_MARK = SCHAR_W'(256);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

endpackage

// ----- hdl/longest_repeat_run_tree.sv -----
// longest_repeat_run_tree: segment tree of run statistics under point writes.
// Node store is an internal single-port-write/single-port-read memory.
// Depends on lrrt_pkg.
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_*      | in  | position[9:0], character[17:10], 0[23:18] | kind[0]
//  m_*      | out | longest_run[10:0], 0[15:11]              | -
//
// After reset a clearing pass writes padding into all 2*LEAVES node slots
// (LEAVES = POSITIONS rounded up to a power of two).
// A transaction writes its leaf, then climbs one tree level per cycle through the
// shared join unit: sibling read and parent write overlap.
// An update then passes a send state to load the output register, and waits there
// while an earlier result is still unaccepted. A write beyond POSITIONS only reads
// the root.
module longest_repeat_run_tree #(
  parameter int POSITIONS = lrrt_pkg::DEF_POSITIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position[9:0], character[17:10], zero pad
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // longest_run[10:0], zero pad
);

  localparam int LOG    = $clog2(POSITIONS);
  localparam int LEAVES = 1 << LOG;
  localparam int ADDR_W = LOG + 1;
  localparam int DEPTH  = 2 * LEAVES;
  localparam int CW     = LOG + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_JOIN  = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);

  typedef struct packed {
    logic [CW-1:0]                    best;
    logic [CW-1:0]                    head;
    logic [CW-1:0]                    tail;
    logic [lrrt_pkg::SCHAR_W-1:0]     first;
    logic [lrrt_pkg::SCHAR_W-1:0]     last;
  } node_t;

  localparam node_t PAD_NODE = '{best: '0, head: '0, tail: '0,
                                 first: lrrt_pkg::PAD_MARK, last: lrrt_pkg::PAD_MARK};

  node_t mem [DEPTH];
  node_t rdata;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] idx;
  logic [CW-1:0]     size;
  node_t             cur;
  logic              kind;
  logic [lrrt_pkg::OUT_W-1:0] result;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  node_t             wdata;

  logic [lrrt_pkg::POS_W-1:0]  in_pos;
  logic [lrrt_pkg::CHAR_W-1:0] in_char;
  logic                        in_kind;
  logic                        pos_ok;
  logic [ADDR_W-1:0]           leaf_addr;
  node_t                       leaf_node;
  logic                        accept;

  node_t             lnode, rnode, joined;
  logic              match;
  logic [CW-1:0]     bridge;
  logic [ADDR_W-1:0] parent;

  assign in_pos    = s_tdata[9:0];
  assign in_char   = s_tdata[17:10];
  assign in_kind   = s_tuser[0];
  assign pos_ok    = 32'(in_pos) < POSITIONS;
  assign leaf_addr = {1'b1, LOG'(in_pos)};
  assign leaf_node = '{best: CW'(1), head: CW'(1), tail: CW'(1),
                       first: {1'b0, in_char}, last: {1'b0, in_char}};
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign parent    = idx >> 1;

  // shared join unit: current node against its sibling from memory
  always_comb begin
    lnode  = idx[0] ? rdata : cur;
    rnode  = idx[0] ? cur : rdata;
    match  = !lnode.last[lrrt_pkg::SCHAR_W-1] && !rnode.first[lrrt_pkg::SCHAR_W-1]
             && (lnode.last == rnode.first);
    bridge = lnode.tail + rnode.head;
    joined.first = lnode.first;
    joined.last  = rnode.last;
    joined.head  = lnode.head;
    joined.tail  = rnode.tail;
    joined.best  = (lnode.best > rnode.best) ? lnode.best : rnode.best;
    if (match) begin
      if (bridge > joined.best) joined.best = bridge;
      if (lnode.head == size) joined.head = size + rnode.head;
      if (rnode.tail == size) joined.tail = size + lnode.tail;
    end
  end

  always_comb begin
    we         = 1'b0;
    waddr      = clr_addr;
    wdata      = PAD_NODE;
    raddr      = ROOT_ADDR;
    state_next = state;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (pos_ok) begin
            we         = 1'b1;
            waddr      = leaf_addr;
            wdata      = leaf_node;
            raddr      = leaf_addr ^ ADDR_W'(1);
            state_next = S_JOIN;
          end else if (in_kind == lrrt_pkg::KIND_UPDATE) begin
            state_next = S_ROOT;
          end
        end
      end
      S_JOIN: begin
        we    = 1'b1;
        waddr = parent;
        wdata = joined;
        raddr = parent ^ ADDR_W'(1);
        if (parent == ROOT_ADDR) begin
          state_next = (kind == lrrt_pkg::KIND_UPDATE) ? S_SEND : S_IDLE;
        end
      end
      S_ROOT: state_next = S_SEND;
      S_SEND: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (state == S_SEND && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= in_kind;
      cur  <= leaf_node;
      idx  <= leaf_addr;
      size <= CW'(1);
    end else if (state == S_JOIN) begin
      cur  <= joined;
      idx  <= parent;
      size <= size << 1;
      if (parent == ROOT_ADDR) result <= lrrt_pkg::OUT_W'(joined.best);
    end else if (state == S_ROOT) begin
      result <= lrrt_pkg::OUT_W'(rdata.best);
    end
    if (state == S_SEND && (!m_tvalid || m_tready)) begin
      m_tdata <= {(16 - lrrt_pkg::OUT_W)'(0), result};
    end
  end

  a_size_pow2: assert property (@(posedge clk) disable iff (rst)
    (state == S_JOIN) |-> $onehot(size))
    else $error("join size not a power of two");

  a_idx_below_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_JOIN) |-> (idx[ADDR_W-1:1] != '0))
    else $error("join started at the root");

  a_join_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_JOIN) |-> (joined.head <= joined.best && joined.tail <= joined.best
                           && joined.best <= (size << 1)))
    else $error("joined run lengths inconsistent");

  a_oob_update: assert property (@(posedge clk) disable iff (rst)
    (accept && !pos_ok && in_kind == lrrt_pkg::KIND_UPDATE) |=> (state == S_ROOT))
    else $error("out-of-range update did not read the root");

  a_send_after_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |=> (state == S_SEND))
    else $error("root read not followed by result");

endmodule
